@@ hdl/cds_pkg.sv @@
// Shared types, constants and calendar helpers for the calendar date stepper.
// Used by every module in hdl/; depends on nothing else.
package cds_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int OP_W     = 2;
    localparam int ORD_W    = 2;
    localparam int PACKED_W = 27;
    localparam int REM_W    = 7;
    localparam int CENT_W   = 8;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 56;

    // operation codes
    localparam logic [OP_W-1:0] OP_FORWARD = 2'd0;
    localparam logic [OP_W-1:0] OP_BACK    = 2'd1;
    localparam logic [OP_W-1:0] OP_LOAD    = 2'd2;
    // unused code: the date holds
    localparam logic [OP_W-1:0] OP_HOLD    = 2'd3;

    // order codes: stored date against input date
    localparam logic [ORD_W-1:0] ORD_EQUAL   = 2'd0;
    localparam logic [ORD_W-1:0] ORD_LATER   = 2'd1;
    localparam logic [ORD_W-1:0] ORD_EARLIER = 2'd2;

    localparam logic [YEAR_W-1:0]  YEAR_MIN   = 14'd1;
    localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
    localparam logic [YEAR_W-1:0]  YEAR_RESET = 14'd1900;
    localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR  = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN  = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP  = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV  = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_FIRST  = 5'd1;
    localparam logic [DAY_W-1:0]   DAY_LAST31 = 5'd31;

    // year split as 100*cent + rem; 1900 = 19 centuries, 19 mod 4 = 3
    localparam logic [REM_W-1:0] REM_RESET  = 7'd0;
    localparam logic [REM_W-1:0] REM_LAST   = 7'd99;
    localparam logic [1:0]       CENT_RESET = 2'd3;

    // floor(y / 100) = (y * 5243) >> 19, exact for every 14-bit y
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;
    localparam int          DIV100_PROD_W = YEAR_W + 13;

    localparam logic [YEAR_W-1:0]   HUNDRED_Y  = 14'd100;
    localparam logic [PACKED_W-1:0] TEN_THOUSAND = 27'd10000;
    localparam logic [PACKED_W-1:0] HUNDRED_P  = 27'd100;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } cds_item_t;

    typedef struct packed {
        cds_item_t         item;
        logic [REM_W-1:0]  rem100;
        logic [1:0]        cent;
        logic              in_valid;
    } cds_dec_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic               leap;
        logic               in_valid;
        logic               at_limit;
        logic [YEAR_W-1:0]  in_year;
        logic [MONTH_W-1:0] in_month;
        logic [DAY_W-1:0]   in_day;
    } cds_upd_t;

    // Gregorian leap rule on the split year; rem mod 4 equals year mod 4
    function automatic logic leap_of(logic [REM_W-1:0] rem100, logic [1:0] cent);
        return ((rem100 != '0) && (rem100[1:0] == 2'd0)) ||
               ((rem100 == '0) && (cent == 2'd0));
    endfunction

    function automatic logic [DAY_W-1:0] month_len(logic [MONTH_W-1:0] month, logic leap);
        logic [DAY_W-1:0] len;
        unique case (month)
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
            default: len = DAY_LAST31;
        endcase
        return len;
    endfunction

endpackage

@@ hdl/cds_in_decode.sv @@
// Input register and two decode stages: splits the input year into
// centuries and remainder, then derives its leap flag and date validity.
// Depends on cds_pkg.
module cds_in_decode (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cds_pkg::cds_item_t in_item,
    output logic              dec_valid,
    input  logic              dec_ready,
    output cds_pkg::cds_dec_t  dec
);

    logic                          s0_vld_reg, s0_vld_next;
    cds_pkg::cds_item_t            s0_item_reg, s0_item_next;
    logic                          s1_vld_reg, s1_vld_next;
    cds_pkg::cds_item_t            s1_item_reg, s1_item_next;
    logic [cds_pkg::CENT_W-1:0]    s1_cent_reg, s1_cent_next;
    logic                          s2_vld_reg, s2_vld_next;
    cds_pkg::cds_dec_t             s2_dec_reg, s2_dec_next;

    logic                               s0_rdy, s1_rdy, s2_rdy;
    logic [cds_pkg::DIV100_PROD_W-1:0]  div_prod;
    logic [cds_pkg::YEAR_W-1:0]         hundreds;
    logic [cds_pkg::REM_W-1:0]          rem100;
    logic                               in_leap;
    cds_pkg::cds_dec_t                  dec_calc;

    assign s2_rdy   = !s2_vld_reg || dec_ready;
    assign s1_rdy   = !s1_vld_reg || s2_rdy;
    assign s0_rdy   = !s0_vld_reg || s1_rdy;
    assign in_ready = s0_rdy;

    // centuries of the input year by reciprocal multiply
    assign div_prod = cds_pkg::DIV100_PROD_W'(s0_item_reg.year) *
                      cds_pkg::DIV100_PROD_W'(cds_pkg::DIV100_MUL);

    assign hundreds = cds_pkg::YEAR_W'(s1_cent_reg) * cds_pkg::HUNDRED_Y;
    assign rem100   = cds_pkg::REM_W'(s1_item_reg.year - hundreds);
    assign in_leap  = cds_pkg::leap_of(rem100, s1_cent_reg[1:0]);

    always_comb
    begin
        dec_calc.item     = s1_item_reg;
        dec_calc.rem100   = rem100;
        dec_calc.cent     = s1_cent_reg[1:0];
        dec_calc.in_valid = (s1_item_reg.year >= cds_pkg::YEAR_MIN) &&
                            (s1_item_reg.year <= cds_pkg::YEAR_MAX) &&
                            (s1_item_reg.month >= cds_pkg::MONTH_JAN) &&
                            (s1_item_reg.month <= cds_pkg::MONTH_DEC) &&
                            (s1_item_reg.day >= cds_pkg::DAY_FIRST) &&
                            (s1_item_reg.day <=
                             cds_pkg::month_len(s1_item_reg.month, in_leap));
    end

    always_comb
    begin
        s0_vld_next  = s0_rdy ? in_valid : s0_vld_reg;
        s0_item_next = (in_valid && s0_rdy) ? in_item : s0_item_reg;
        s1_vld_next  = s1_rdy ? s0_vld_reg : s1_vld_reg;
        s1_item_next = (s0_vld_reg && s1_rdy) ? s0_item_reg : s1_item_reg;
        s1_cent_next = (s0_vld_reg && s1_rdy) ?
                       div_prod[cds_pkg::DIV100_SHIFT +: cds_pkg::CENT_W] : s1_cent_reg;
        s2_vld_next  = s2_rdy ? s1_vld_reg : s2_vld_reg;
        s2_dec_next  = (s1_vld_reg && s2_rdy) ? dec_calc : s2_dec_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s0_vld_reg <= s0_vld_next;
            s1_vld_reg <= s1_vld_next;
            s2_vld_reg <= s2_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_item_reg <= s0_item_next;
        s1_item_reg <= s1_item_next;
        s1_cent_reg <= s1_cent_next;
        s2_dec_reg  <= s2_dec_next;
    end

    assign dec_valid = s2_vld_reg;
    assign dec       = s2_dec_reg;

endmodule

@@ hdl/cds_date_core.sv @@
// Stored date and its update: step forward, step back or load (code 3 holds it).
// Registers the new date with its flags for the output stage. Depends on cds_pkg.
module cds_date_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              dec_valid,
    output logic              dec_ready,
    input  cds_pkg::cds_dec_t  dec,
    output logic              upd_valid,
    input  logic              upd_ready,
    output cds_pkg::cds_upd_t  upd
);

    logic [cds_pkg::YEAR_W-1:0]  year_reg, year_next;
    logic [cds_pkg::MONTH_W-1:0] month_reg, month_next;
    logic [cds_pkg::DAY_W-1:0]   day_reg, day_next;
    logic [cds_pkg::REM_W-1:0]   rem_reg, rem_next;
    logic [1:0]                  cent_reg, cent_next;
    logic                        r1_vld_reg, r1_vld_next;
    cds_pkg::cds_upd_t           r1_upd_reg, r1_upd_next;

    logic                        r1_rdy;
    logic                        apply;
    logic                        limit;
    logic                        cur_leap;
    logic [cds_pkg::DAY_W-1:0]   cur_len;
    logic [cds_pkg::DAY_W-1:0]   prev_len;

    assign r1_rdy    = !r1_vld_reg || upd_ready;
    assign dec_ready = r1_rdy;
    assign apply     = dec_valid && r1_rdy;

    assign cur_leap = cds_pkg::leap_of(rem_reg, cent_reg);
    assign cur_len  = cds_pkg::month_len(month_reg, cur_leap);
    assign prev_len = cds_pkg::month_len(month_reg - 4'd1, cur_leap);

    always_comb
    begin
        year_next  = year_reg;
        month_next = month_reg;
        day_next   = day_reg;
        rem_next   = rem_reg;
        cent_next  = cent_reg;
        limit      = 1'b0;
        if (apply)
        begin
            unique case (dec.item.op)
                cds_pkg::OP_FORWARD:
                begin
                    priority if (day_reg < cur_len)
                    begin
                        day_next = day_reg + 5'd1;
                    end
                    else if (month_reg < cds_pkg::MONTH_DEC)
                    begin
                        month_next = month_reg + 4'd1;
                        day_next   = cds_pkg::DAY_FIRST;
                    end
                    else if (year_reg < cds_pkg::YEAR_MAX)
                    begin
                        year_next  = year_reg + 14'd1;
                        month_next = cds_pkg::MONTH_JAN;
                        day_next   = cds_pkg::DAY_FIRST;
                        if (rem_reg == cds_pkg::REM_LAST)
                        begin
                            rem_next  = '0;
                            cent_next = cent_reg + 2'd1;
                        end
                        else
                        begin
                            rem_next = rem_reg + 7'd1;
                        end
                    end
                    else
                    begin
                        limit = 1'b1;
                    end
                end
                cds_pkg::OP_BACK:
                begin
                    priority if (day_reg > cds_pkg::DAY_FIRST)
                    begin
                        day_next = day_reg - 5'd1;
                    end
                    else if (month_reg > cds_pkg::MONTH_JAN)
                    begin
                        month_next = month_reg - 4'd1;
                        day_next   = prev_len;
                    end
                    else if (year_reg > cds_pkg::YEAR_MIN)
                    begin
                        year_next  = year_reg - 14'd1;
                        month_next = cds_pkg::MONTH_DEC;
                        day_next   = cds_pkg::DAY_LAST31;
                        if (rem_reg == '0)
                        begin
                            rem_next  = cds_pkg::REM_LAST;
                            cent_next = cent_reg - 2'd1;
                        end
                        else
                        begin
                            rem_next = rem_reg - 7'd1;
                        end
                    end
                    else
                    begin
                        limit = 1'b1;
                    end
                end
                cds_pkg::OP_LOAD:
                begin
                    if (dec.in_valid)
                    begin
                        year_next  = dec.item.year;
                        month_next = dec.item.month;
                        day_next   = dec.item.day;
                        rem_next   = dec.rem100;
                        cent_next  = dec.cent;
                    end
                    else
                    begin
                        limit = 1'b1;
                    end
                end
                default:
                begin
                    limit = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        r1_vld_next = r1_rdy ? dec_valid : r1_vld_reg;
        r1_upd_next = r1_upd_reg;
        if (apply)
        begin
            r1_upd_next.year     = year_next;
            r1_upd_next.month    = month_next;
            r1_upd_next.day      = day_next;
            r1_upd_next.leap     = cds_pkg::leap_of(rem_next, cent_next);
            r1_upd_next.in_valid = dec.in_valid;
            r1_upd_next.at_limit = limit;
            r1_upd_next.in_year  = dec.item.year;
            r1_upd_next.in_month = dec.item.month;
            r1_upd_next.in_day   = dec.item.day;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_reg   <= cds_pkg::YEAR_RESET;
            month_reg  <= cds_pkg::MONTH_JAN;
            day_reg    <= cds_pkg::DAY_FIRST;
            rem_reg    <= cds_pkg::REM_RESET;
            cent_reg   <= cds_pkg::CENT_RESET;
            r1_vld_reg <= 1'b0;
        end
        else
        begin
            year_reg   <= year_next;
            month_reg  <= month_next;
            day_reg    <= day_next;
            rem_reg    <= rem_next;
            cent_reg   <= cent_next;
            r1_vld_reg <= r1_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r1_upd_reg <= r1_upd_next;
    end

    assign upd_valid = r1_vld_reg;
    assign upd       = r1_upd_reg;

    a_date_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (year_reg >= cds_pkg::YEAR_MIN) && (year_reg <= cds_pkg::YEAR_MAX) &&
        (month_reg >= cds_pkg::MONTH_JAN) && (month_reg <= cds_pkg::MONTH_DEC) &&
        (day_reg >= cds_pkg::DAY_FIRST))
        else $error("stored date out of range");

    a_day_fits_month: assert property (@(posedge clk) disable iff (!rst_n)
        day_reg <= cur_len)
        else $error("stored day exceeds month length");

    a_year_split: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg <= cds_pkg::REM_LAST)
        else $error("year remainder counter out of range");

    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !apply |=> $stable(year_reg) && $stable(month_reg) && $stable(day_reg) &&
                   $stable(rem_reg) && $stable(cent_reg))
        else $error("stored date changed without an item");

endmodule

@@ hdl/cds_out_format.sv @@
// Result register: forms the packed decimal date and the date ordering
// from the updated date and drives the output item. Depends on cds_pkg.
module cds_out_format (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           upd_valid,
    output logic                           upd_ready,
    input  cds_pkg::cds_upd_t               upd,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [cds_pkg::M_DATA_W-1:0]   out_data
);

    logic                                 out_vld_reg, out_vld_next;
    logic [cds_pkg::M_DATA_W-1:0]         out_data_reg, out_data_next;

    logic                                 out_rdy;
    logic [cds_pkg::PACKED_W-1:0]         packed_dec;
    logic [cds_pkg::ORD_W-1:0]            ord;
    logic [cds_pkg::YEAR_W+cds_pkg::MONTH_W+cds_pkg::DAY_W-1:0] cur_key, in_key;

    assign out_rdy   = !out_vld_reg || out_ready;
    assign upd_ready = out_rdy;

    assign packed_dec = cds_pkg::PACKED_W'(upd.year) * cds_pkg::TEN_THOUSAND +
                        cds_pkg::PACKED_W'(upd.month) * cds_pkg::HUNDRED_P +
                        cds_pkg::PACKED_W'(upd.day);

    // year, then month, then day
    assign cur_key = {upd.year, upd.month, upd.day};
    assign in_key  = {upd.in_year, upd.in_month, upd.in_day};

    always_comb
    begin
        priority if (cur_key == in_key)
            ord = cds_pkg::ORD_EQUAL;
        else if (cur_key > in_key)
            ord = cds_pkg::ORD_LATER;
        else
            ord = cds_pkg::ORD_EARLIER;
    end

    always_comb
    begin
        out_vld_next  = out_rdy ? upd_valid : out_vld_reg;
        out_data_next = (upd_valid && out_rdy) ?
                        {1'b0, upd.at_limit, ord, packed_dec, upd.in_valid, upd.leap,
                         upd.day, upd.month, upd.year} :
                        out_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_data_reg;

endmodule

@@ hdl/calendar_date_stepper.sv @@
// Gregorian date stepper: holds one date and steps it forward or back one
// day, or loads a new one, for each item taken on the slave stream.
//
// Input: s_axis_tuser carries the operation (0 forward, 1 back, 2 load),
// s_axis_tdata the date to load or compare. Output: one result item per
// input item on m_axis, in order: the stored date after the item, its leap
// flag, the input date's validity, the date as decimal YYYYMMDD, the order
// of stored against input date and a limit flag (step held at 0001-01-01
// or 9999-12-31, or load of an invalid date rejected).
// Throughput is one item per cycle while m_axis_tready is high. Each
// accepted item passes through the input register, two decode
// stages (year split by reciprocal multiply, then leap and validity),
// the date update and the result stage with the packed-decimal multiply.
// Each stage holds its item while the next one is full, so a stalled
// m_axis_tready fills the stages and only then drops s_axis_tready.
// Reset clears all stages and sets the stored date to 1900-01-01.
// Depends on cds_pkg, cds_in_decode, cds_date_core, cds_out_format.
module calendar_date_stepper (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [13:0] in_year, [17:14] in_month, [22:18] in_day, [23] zero
    input  logic [cds_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // [1:0] operation
    input  logic [cds_pkg::OP_W-1:0]      s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [13:0] cur_year, [17:14] cur_month, [22:18] cur_day, [23] leap_flag,
    // [24] input_valid, [51:25] packed_decimal, [53:52] order,
    // [54] at_limit, [55] zero
    output logic [cds_pkg::M_DATA_W-1:0]  m_axis_tdata
);

    cds_pkg::cds_item_t in_item;
    cds_pkg::cds_dec_t  dec;
    cds_pkg::cds_upd_t  upd;
    logic               dec_valid, dec_ready;
    logic               upd_valid, upd_ready;

    assign in_item.op    = s_axis_tuser;
    assign in_item.year  = s_axis_tdata[13:0];
    assign in_item.month = s_axis_tdata[17:14];
    assign in_item.day   = s_axis_tdata[22:18];

    cds_in_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (in_item),
        .dec_valid (dec_valid),
        .dec_ready (dec_ready),
        .dec       (dec)
    );

    cds_date_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .dec_valid (dec_valid),
        .dec_ready (dec_ready),
        .dec       (dec),
        .upd_valid (upd_valid),
        .upd_ready (upd_ready),
        .upd       (upd)
    );

    cds_out_format u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .upd_valid (upd_valid),
        .upd_ready (upd_ready),
        .upd       (upd),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule
